>>> hdl/alte_pkg.sv
`default_nettype none
package alte_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int WORD_WIDTH_DEF = 32;

    localparam logic [8:0] CAP_RESET = 9'd256;

    localparam logic [2:0] CMD_APPEND  = 3'd0;
    localparam logic [2:0] CMD_REPLACE = 3'd1;
    localparam logic [2:0] CMD_READ    = 3'd2;
    localparam logic [2:0] CMD_POP     = 3'd3;
    localparam logic [2:0] CMD_DELETE  = 3'd4;
    localparam logic [2:0] CMD_FIND    = 3'd5;
    localparam logic [2:0] CMD_CLEAR   = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_INDEX = 2'd3;

    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
        logic [7:0]         index;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_data;
        logic               found;
        logic [8:0]         entry_count;
    } t_res_item;

endpackage
`default_nettype wire

>>> hdl/alte_store.sv
`default_nettype none
module alte_store #(
    parameter int DEPTH      = alte_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = alte_pkg::WORD_WIDTH_DEF,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [WORD_WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]         i_raddr,
    output logic [WORD_WIDTH-1:0]      o_rdata
);

    logic [WORD_WIDTH-1:0] r_mem [DEPTH];
    logic [WORD_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hdl/alte_seq.sv
`default_nettype none
module alte_seq #(
    parameter int DEPTH      = alte_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = alte_pkg::WORD_WIDTH_DEF,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int XW        = (CW > 9) ? CW : 9
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [8:0]            i_cap,
    input  wire logic                  start,
    input  wire alte_pkg::t_cmd_item   i_cmd,
    output logic                       busy,
    output logic                       o_res_valid,
    output alte_pkg::t_res_item        o_res,
    output logic                       o_mem_we,
    output logic [AW-1:0]              o_mem_waddr,
    output logic [WORD_WIDTH-1:0]      o_mem_wdata,
    output logic [AW-1:0]              o_mem_raddr,
    input  wire logic [WORD_WIDTH-1:0] i_mem_rdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RDW  = 3'd2;
    localparam logic [2:0] S_DEL  = 3'd3;
    localparam logic [2:0] S_FIND = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [2:0]            r_cmd, n_cmd;
    logic [WORD_WIDTH-1:0] r_word, n_word;
    logic [7:0]            r_idx, n_idx;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_ptr, n_ptr;
    logic                  r_pend, n_pend;
    logic [AW-1:0]         r_pa, n_pa;
    logic                  r_valid, n_valid;
    alte_pkg::t_res_item   r_res, n_res;

    logic [XW-1:0] cap_x, eff_cap, cnt_x, idx_x, ptr_x;
    logic          empty, full, idx_bad, ptr_lt, eq;
    logic [63:0]   vext;
    logic signed [WORD_WIDTH-1:0] rd_s;
    logic signed [63:0]           rd_l;

    logic        fin;
    logic [1:0]  res_st;
    logic [31:0] res_rd;
    logic        res_found;

    // shared compare unit
    assign cap_x   = XW'(i_cap);
    assign cnt_x   = XW'(r_count);
    assign idx_x   = XW'(r_idx);
    assign ptr_x   = XW'(r_ptr);
    assign empty   = (r_count == '0);
    assign full    = (cnt_x >= eff_cap);
    assign idx_bad = (idx_x >= cnt_x);
    assign ptr_lt  = (ptr_x < cnt_x);
    assign eq      = (i_mem_rdata == r_word);

    assign vext = {{32{i_cmd.value[31]}}, i_cmd.value};
    assign rd_s = i_mem_rdata;
    assign rd_l = 64'(rd_s);

    always_comb begin
        eff_cap = cap_x;
        if (cap_x == '0) begin
            eff_cap = XW'(1);
        end else if (cap_x > XW'(DEPTH)) begin
            eff_cap = XW'(DEPTH);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_word      = r_word;
        n_idx       = r_idx;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_pa        = r_pa;
        n_valid     = 1'b0;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = AW'(r_count);
        o_mem_wdata = r_word;
        o_mem_raddr = AW'(r_ptr);
        fin         = 1'b0;
        res_st      = alte_pkg::ST_OK;
        res_rd      = '0;
        res_found   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd.command;
                    n_word  = vext[WORD_WIDTH-1:0];
                    n_idx   = i_cmd.index;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    alte_pkg::CMD_APPEND: begin
                        fin = 1'b1;
                        if (full) begin
                            res_st = alte_pkg::ST_FULL;
                        end else begin
                            o_mem_we = 1'b1;
                            n_count  = r_count + CW'(1);
                        end
                    end
                    alte_pkg::CMD_REPLACE: begin
                        fin = 1'b1;
                        if (empty) begin
                            if (full) begin
                                res_st = alte_pkg::ST_FULL;
                            end else begin
                                o_mem_we = 1'b1;
                                n_count  = r_count + CW'(1);
                            end
                        end else if (idx_bad) begin
                            res_st = alte_pkg::ST_INDEX;
                        end else begin
                            o_mem_we    = 1'b1;
                            o_mem_waddr = AW'(r_idx);
                        end
                    end
                    alte_pkg::CMD_READ: begin
                        if (empty) begin
                            fin    = 1'b1;
                            res_st = alte_pkg::ST_EMPTY;
                        end else if (idx_bad) begin
                            fin    = 1'b1;
                            res_st = alte_pkg::ST_INDEX;
                        end else begin
                            o_mem_raddr = AW'(r_idx);
                            n_state     = S_RDW;
                        end
                    end
                    alte_pkg::CMD_POP: begin
                        fin = 1'b1;
                        if (empty) begin
                            res_st = alte_pkg::ST_EMPTY;
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end
                    alte_pkg::CMD_DELETE: begin
                        if (empty) begin
                            fin    = 1'b1;
                            res_st = alte_pkg::ST_EMPTY;
                        end else if (idx_bad) begin
                            fin    = 1'b1;
                            res_st = alte_pkg::ST_INDEX;
                        end else begin
                            n_ptr   = CW'(idx_x + XW'(1));
                            n_pend  = 1'b0;
                            n_state = S_DEL;
                        end
                    end
                    alte_pkg::CMD_FIND: begin
                        if (empty) begin
                            fin    = 1'b1;
                            res_st = alte_pkg::ST_EMPTY;
                        end else begin
                            n_ptr   = '0;
                            n_pend  = 1'b0;
                            n_state = S_FIND;
                        end
                    end
                    alte_pkg::CMD_CLEAR: begin
                        fin     = 1'b1;
                        n_count = '0;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_RDW: begin
                fin    = 1'b1;
                res_rd = rd_l[31:0];
            end
            S_DEL: begin
                // read one entry ahead, write it one slot down in the following cycle
                if (r_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_pa;
                    o_mem_wdata = i_mem_rdata;
                end
                if (ptr_lt) begin
                    o_mem_raddr = AW'(r_ptr);
                    n_pend      = 1'b1;
                    n_pa        = AW'(r_ptr - CW'(1));
                    n_ptr       = r_ptr + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        fin     = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            S_FIND: begin
                if (r_pend && eq) begin
                    fin       = 1'b1;
                    res_found = 1'b1;
                end else if (ptr_lt) begin
                    o_mem_raddr = AW'(r_ptr);
                    n_pend      = 1'b1;
                    n_ptr       = r_ptr + CW'(1);
                end else begin
                    fin = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state             = S_IDLE;
            n_valid             = 1'b1;
            n_res.status        = res_st;
            n_res.read_data     = res_rd;
            n_res.found         = res_found;
            n_res.entry_count   = 9'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
        r_cmd  <= n_cmd;
        r_word <= n_word;
        r_idx  <= n_idx;
        r_ptr  <= n_ptr;
        r_pa   <= n_pa;
        r_res  <= n_res;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_valid;
    assign o_res       = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(DEPTH))
        else $error("entry count beyond depth");

    a_count_moves_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |-> r_valid)
        else $error("entry count changed without a result");

    a_write_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state != S_IDLE))
        else $error("store written while idle");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL || r_state == S_FIND) |-> (ptr_x <= cnt_x))
        else $error("walk pointer past last entry");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result shown while still busy");

endmodule
`default_nettype wire

>>> hdl/array_list_table_engine.sv
// channel   ports                              handshake
// command   i_cmd (t_cmd_item)                 accepted when start && !busy
// result    o_res (t_res_item)                 one cycle, o_res_valid high
// config    psel penable pwrite paddr pwdata   write on psel && penable && pwrite
//           prdata pready                      pready high, paddr[2]=0 reads capacity
//
// append, replace, pop, clear and unknown commands finish in the execute step
// read adds one registered read of the entry store before its result
// delete at moves the entries above the index one slot down; find stops at a match or
// the count, walking the entry store through its single read port one entry per cycle
// reset clears the count and sets capacity to 256 at once; store contents are not cleared
// results cannot be stalled: each is shown for one cycle only
`default_nettype none
module array_list_table_engine #(
    parameter int DEPTH      = alte_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = alte_pkg::WORD_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire alte_pkg::t_cmd_item i_cmd,
    output logic                     busy,
    output logic                     o_res_valid,
    output alte_pkg::t_res_item      o_res,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [8:0]            r_cap;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [WORD_WIDTH-1:0] mem_wdata, mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= alte_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == alte_pkg::REG_CAPACITY)) begin
            r_cap <= pwdata[8:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == alte_pkg::REG_CAPACITY) ? {23'd0, r_cap} : 32'd0;

    alte_seq #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (r_cap),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    alte_store #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
`default_nettype wire
